// ----- hdl/wrps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrps_pkg
// Codes, field widths and the command arbiter shared by the poll sequencer.
// ----------------------------------------------------------------------------
package wrps_pkg;

    localparam int RAW_W   = 16;
    localparam int N_MEAS  = 6;
    localparam int PHASE_W = 3;
    localparam int CMD_W   = 2;
    localparam int TMR_W   = 2;
    localparam int KIND_W  = 2;

    // phases
    localparam logic [PHASE_W-1:0] PH_DOWN    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_READ    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LDO_ON  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LDO_OFF = 3'd4;

    // commands
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ON   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OFF  = 2'd3;

    // timer actions
    localparam logic [TMR_W-1:0] TMR_NONE  = 2'd0;
    localparam logic [TMR_W-1:0] TMR_START = 2'd1;
    localparam logic [TMR_W-1:0] TMR_STOP  = 2'd2;

    // event kinds
    localparam logic [KIND_W-1:0] EV_TICK = 2'd0;
    localparam logic [KIND_W-1:0] EV_PIN  = 2'd1;
    localparam logic [KIND_W-1:0] EV_LDO  = 2'd2;
    localparam logic [KIND_W-1:0] EV_XFER = 2'd3;

    // status byte: output ready flag
    localparam int READY_BIT = 6;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CMD_W-1:0]   cmd;
    } t_adv;

    // Command arbiter: readout from power-down, then LDO fix-up, then readout.
    function automatic t_adv f_advance(
        input logic [PHASE_W-1:0] phase,
        input logic               pending,
        input logic               ldo_on,
        input logic               ldo_wanted
    );
        t_adv res;
        res.phase = phase;
        res.cmd   = CMD_NONE;
        if (phase == PH_DOWN && pending) begin
            res.phase = PH_READ;
            res.cmd   = CMD_READ;
        end else if (phase == PH_IDLE) begin
            if (ldo_on != ldo_wanted) begin
                res.phase = ldo_wanted ? PH_LDO_ON : PH_LDO_OFF;
                res.cmd   = ldo_wanted ? CMD_ON : CMD_OFF;
            end else if (pending) begin
                res.phase = PH_READ;
                res.cmd   = CMD_READ;
            end
        end
        return res;
    endfunction

endpackage

// ----- hdl/wireless_rx_poll_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wireless_rx_poll_sequencer
// Event-driven poll sequencer for a wireless charging receiver: picks the
// next bus command, drives the readout timer and latches the last report.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata / tuser contents
//  ----------+-----------+-----------------------------------------------------
//  s (event) | in        | tuser: event kind; tdata: LDO request, xfer status,
//            |           | six raw measurement words, status byte
//  m (result)| out       | tdata: command, timer action, phase, flags,
//            |           | six latched measurements, LDO state
//
//  One event per cycle. The event is decoded against the state registers and
//  the result lands in a single output register in the cycle after the transfer.
//  Input is taken whenever the output register is empty or is being drained
//  in the same cycle, so the rate is one event per clock while the sink keeps
//  up; a stalled sink holds the result and back-pressures the source.
//  Synchronous active-low reset: phase power down, LDO on and wanted on,
//  report invalid, measurements zero, output register empty.
// ----------------------------------------------------------------------------
module wireless_rx_poll_sequencer
    import wrps_pkg::*;
#(
    parameter int MEAS_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // event channel
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [1:0] req_type
    input  logic [1:0]   i_s_tuser,
    // [0] ldo_request, [1] xfer_ok, [17:2] rect_voltage_raw,
    // [33:18] out_voltage_raw, [49:34] current_raw, [65:50] die_temp_raw,
    // [81:66] op_freq_raw, [97:82] ntc_temp_raw, [105:98] irq_status_raw,
    // [111:106] zero
    input  logic [111:0] i_s_tdata,
    // result channel
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [1:0] command, [3:2] timer_action, [6:4] phase_now, [7] report_ready,
    // [8] output_ready, [24:9] rect_mv, [40:25] out_mv,
    // [56:41] current_reading, [72:57] die_temp_tenths,
    // [88:73] freq_reading, [104:89] ntc_temp_tenths, [105] ldo_is_on,
    // [111:106] zero
    output logic [111:0] o_m_tdata
);

    // stored measurement width: the bus words are 16 bits, so never wider
    localparam int STORE_W = (MEAS_WIDTH < RAW_W) ? MEAS_WIDTH : RAW_W;
    localparam int MEAS_LO = 2;               // first measurement bit in tdata
    localparam int IRQ_LO  = MEAS_LO + N_MEAS * RAW_W;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TMR_W-1:0]   tmr;
        logic [PHASE_W-1:0] phase;
        logic               report_ready;
        logic               output_ready;
        logic               ldo_is_on;
    } t_res_ctl;

    // sequencer state
    logic [PHASE_W-1:0] r_phase,   n_phase;
    logic               r_pending, n_pending;
    logic               r_ldo_on,  n_ldo_on;
    logic               r_wanted,  n_wanted;
    logic               r_valid,   n_valid;
    logic               r_rdy,     n_rdy;
    logic [STORE_W-1:0] r_meas [N_MEAS];
    logic [STORE_W-1:0] n_meas [N_MEAS];

    // result register
    logic               r_out_valid;
    t_res_ctl           r_out_ctl;
    t_res_ctl           n_out_ctl;
    logic [RAW_W-1:0]   r_out_meas [N_MEAS];

    logic               accept;
    logic               ev_want;
    logic               ev_ok;
    logic [7:0]         ev_irq;
    t_adv               adv;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign ev_want    = i_s_tdata[0];
    assign ev_ok      = i_s_tdata[1];
    assign ev_irq     = i_s_tdata[IRQ_LO +: 8];

    // event decode and next state
    always_comb begin
        logic [PHASE_W-1:0] ph;
        logic               pend;
        logic               on;
        logic               want;
        logic [CMD_W-1:0]   cmd;
        logic [TMR_W-1:0]   tmr;

        ph        = r_phase;
        pend      = r_pending;
        on        = r_ldo_on;
        want      = r_wanted;
        cmd       = CMD_NONE;
        tmr       = TMR_NONE;
        n_valid   = r_valid;
        n_rdy     = r_rdy;
        for (int k = 0; k < N_MEAS; k++) begin
            n_meas[k] = r_meas[k];
        end
        adv = f_advance(ph, pend, on, want);

        case (i_s_tuser)
            EV_TICK: begin
                pend = 1'b1;
                adv  = f_advance(ph, pend, on, want);
                ph   = adv.phase;
                cmd  = adv.cmd;
            end
            EV_PIN: begin
                // ignored unless powered down
                if (ph == PH_DOWN) begin
                    pend = 1'b1;
                    adv  = f_advance(ph, pend, on, want);
                    ph   = adv.phase;
                    cmd  = adv.cmd;
                end
            end
            EV_LDO: begin
                if (want != ev_want) begin
                    want = ev_want;
                    adv  = f_advance(ph, pend, on, want);
                    ph   = adv.phase;
                    cmd  = adv.cmd;
                end
            end
            default: begin
                // completion with nothing in flight is dropped
                if (ph != PH_DOWN && ph != PH_IDLE) begin
                    if (!ev_ok) begin
                        n_valid = 1'b0;
                        n_rdy   = 1'b0;
                        for (int k = 0; k < N_MEAS; k++) begin
                            n_meas[k] = '0;
                        end
                        tmr  = TMR_STOP;
                        ph   = PH_DOWN;
                        pend = 1'b0;
                    end else begin
                        if (ph == PH_READ) begin
                            pend    = 1'b0;
                            n_valid = 1'b1;
                            n_rdy   = ev_irq[READY_BIT];
                            for (int k = 0; k < N_MEAS; k++) begin
                                n_meas[k] = i_s_tdata[MEAS_LO + k*RAW_W +: STORE_W];
                            end
                            // first report: force the LDO command, start polling
                            if (!r_valid) begin
                                on  = !want;
                                tmr = TMR_START;
                            end
                        end else if (ph == PH_LDO_ON) begin
                            on = 1'b1;
                        end else if (ph == PH_LDO_OFF) begin
                            on = 1'b0;
                        end
                        ph  = PH_IDLE;
                        adv = f_advance(ph, pend, on, want);
                        ph  = adv.phase;
                        cmd = adv.cmd;
                    end
                end
            end
        endcase

        n_phase   = ph;
        n_pending = pend;
        n_ldo_on  = on;
        n_wanted  = want;

        n_out_ctl.cmd          = cmd;
        n_out_ctl.tmr          = tmr;
        n_out_ctl.phase        = ph;
        n_out_ctl.report_ready = n_valid;
        n_out_ctl.output_ready = n_rdy;
        n_out_ctl.ldo_is_on    = on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DOWN;
            r_pending   <= 1'b0;
            r_ldo_on    <= 1'b1;
            r_wanted    <= 1'b1;
            r_valid     <= 1'b0;
            r_rdy       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < N_MEAS; k++) begin
                r_meas[k] <= '0;
            end
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
                r_ldo_on  <= n_ldo_on;
                r_wanted  <= n_wanted;
                r_valid   <= n_valid;
                r_rdy     <= n_rdy;
                for (int k = 0; k < N_MEAS; k++) begin
                    r_meas[k] <= n_meas[k];
                end
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_ctl <= n_out_ctl;
            for (int k = 0; k < N_MEAS; k++) begin
                r_out_meas[k] <= RAW_W'(n_meas[k]);
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_m_tdata        = '0;
        o_m_tdata[1:0]   = r_out_ctl.cmd;
        o_m_tdata[3:2]   = r_out_ctl.tmr;
        o_m_tdata[6:4]   = r_out_ctl.phase;
        o_m_tdata[7]     = r_out_ctl.report_ready;
        o_m_tdata[8]     = r_out_ctl.output_ready;
        for (int k = 0; k < N_MEAS; k++) begin
            o_m_tdata[9 + k*RAW_W +: RAW_W] = r_out_meas[k];
        end
        o_m_tdata[105]   = r_out_ctl.ldo_is_on;
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // no report means the latched measurements are cleared
    a_meas_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> (r_meas[0] == '0 && r_meas[1] == '0 && r_meas[2] == '0 &&
                      r_meas[3] == '0 && r_meas[4] == '0 && r_meas[5] == '0))
        else $error("measurements held without a valid report");

    // the ready flag only stands with a valid report
    a_rdy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdy |-> r_valid)
        else $error("output-ready flag set without a report");

    // a failed in-flight transfer returns to power down with nothing pending
    a_fail_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tuser == EV_XFER && !ev_ok &&
         r_phase != PH_DOWN && r_phase != PH_IDLE)
        |=> (r_phase == PH_DOWN && !r_pending && r_out_ctl.tmr == TMR_STOP))
        else $error("failed transfer did not return to power down");

    // an issued readout command leaves the phase in readout
    a_cmd_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ctl.cmd == CMD_READ) |-> r_out_ctl.phase == PH_READ)
        else $error("readout command without readout phase");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wireless receiver poll sequencer. A directed
// walk covers the phase machine: stray and failed completions, power-down
// readouts, the first-readout LDO fix-up, LDO requests in the idle, readout
// and LDO-on phases, and interrupts outside power-down. Weighted random event
// traffic follows. An in-bench model predicts each result. The source sends in
// bursts and the sink stalls on its own schedule, with one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import wrps_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RST_CYCLES      = 6;
    localparam int RANDOM_ITEMS    = 1275;    // random events after the directed table
    localparam int HOLD_AT_ITEM    = 150;     // random item that triggers the hold-off
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;       // registered result, plenty of margin
    localparam int MAX_REPORTED    = 10;
    localparam int WATCHDOG_CYCLES = 600_000;

    // Event tdata, lowest bits last in the list.
    typedef struct packed {
        logic [5:0]                   pad;
        logic [7:0]                   status;
        logic [N_MEAS-1:0][RAW_W-1:0] meas;    // [0] rect ... [5] ntc
        logic                         ok;
        logic                         want;
    } seq_event_t;

    // Result tdata, same layout as o_m_tdata.
    typedef struct packed {
        logic [5:0]                   pad;
        logic                         ldo;
        logic [N_MEAS-1:0][RAW_W-1:0] meas;
        logic                         rdy;
        logic                         rep;
        logic [PHASE_W-1:0]           phase;
        logic [TMR_W-1:0]             tmr;
        logic [CMD_W-1:0]             cmd;
    } seq_result_t;

    // A row may pin its expected result; otherwise the model decides.
    typedef struct {
        bit          typed;
        seq_result_t res;
    } pinned_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        seq_event_t        ev;
        bit                typed;
        seq_result_t       res;
    } stim_row_t;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [1:0]   i_s_tuser  = '0;    // [1:0] req_type
    // [0] ldo_request, [1] xfer_ok, [97:2] six raw words, [105:98] status, [111:106] zero
    logic [111:0] i_s_tdata  = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // [1:0] command, [3:2] timer, [6:4] phase, [7] report, [8] out ready,
    // [104:9] six latched words, [105] ldo_is_on, [111:106] zero
    logic [111:0] o_m_tdata;

    wireless_rx_poll_sequencer #(
        .MEAS_WIDTH(RAW_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Sequencer model state (reset values), updated once per accepted event
    // ------------------------------------------------------------------------
    logic [PHASE_W-1:0]           model_phase    = PH_DOWN;
    bit                           model_pending  = 1'b0;
    bit                           model_ldo_on   = 1'b1;
    bit                           model_ldo_want = 1'b1;
    bit                           model_valid    = 1'b0;
    bit                           model_ready    = 1'b0;
    logic [N_MEAS-1:0][RAW_W-1:0] model_meas     = '0;

    // Expected results in transfer order, plus the per-item pin made by the source.
    seq_result_t due_results [$];
    pinned_t     pinned_rows [$];
    stim_row_t   directed    [$];

    int  failures        = 0;
    int  events_taken    = 0;
    int  acted_events    = 0;
    int  results_seen    = 0;
    int  readouts_armed  = 0;
    int  xfer_aborts     = 0;
    int  ldo_commands    = 0;
    int  holds_done      = 0;
    int  burst_left      = 0;
    bit  hold_req        = 1'b0;

    // Command arbitration: power-down readout, then LDO fix-up, then periodic readout.
    function automatic logic [CMD_W-1:0] pick_command();
        if (model_phase == PH_DOWN && model_pending) begin
            model_phase = PH_READ;
            return CMD_READ;
        end
        if (model_phase != PH_IDLE)
            return CMD_NONE;
        if (model_ldo_on != model_ldo_want) begin
            model_phase = model_ldo_want ? PH_LDO_ON : PH_LDO_OFF;
            return model_ldo_want ? CMD_ON : CMD_OFF;
        end
        if (model_pending) begin
            model_phase = PH_READ;
            return CMD_READ;
        end
        return CMD_NONE;
    endfunction

    // Applies one event to the model and returns the result it produces.
    // acted is cleared for events the sequencer ignores.
    function automatic seq_result_t sequence_event(input logic [KIND_W-1:0] kind,
                                                   input seq_event_t ev,
                                                   output bit acted);
        seq_result_t      r;
        logic [CMD_W-1:0] cmd;
        logic [TMR_W-1:0] tmr;
        cmd   = CMD_NONE;
        tmr   = TMR_NONE;
        acted = 1'b1;
        case (kind)
            EV_TICK: begin
                model_pending = 1'b1;
                cmd = pick_command();
            end
            EV_PIN: begin
                // interrupt only matters while powered down
                if (model_phase == PH_DOWN) begin
                    model_pending = 1'b1;
                    cmd = pick_command();
                end else begin
                    acted = 1'b0;
                end
            end
            EV_LDO: begin
                if (model_ldo_want != ev.want) begin
                    model_ldo_want = ev.want;
                    cmd = pick_command();
                end else begin
                    acted = 1'b0;
                end
            end
            default: begin
                if (model_phase == PH_DOWN || model_phase == PH_IDLE) begin
                    // nothing in flight
                    acted = 1'b0;
                end else if (!ev.ok) begin
                    model_valid   = 1'b0;
                    model_ready   = 1'b0;
                    model_meas    = '0;
                    model_phase   = PH_DOWN;
                    model_pending = 1'b0;
                    tmr           = TMR_STOP;
                end else begin
                    if (model_phase == PH_READ) begin
                        // first report: LDO assumed opposite of wanted, timer armed
                        if (!model_valid) begin
                            model_ldo_on = !model_ldo_want;
                            tmr          = TMR_START;
                        end
                        model_pending = 1'b0;
                        model_valid   = 1'b1;
                        model_ready   = ev.status[READY_BIT];
                        model_meas    = ev.meas;
                    end else if (model_phase == PH_LDO_ON) begin
                        model_ldo_on = 1'b1;
                    end else if (model_phase == PH_LDO_OFF) begin
                        model_ldo_on = 1'b0;
                    end
                    model_phase = PH_IDLE;
                    cmd = pick_command();
                end
            end
        endcase
        r       = '0;
        r.cmd   = cmd;
        r.tmr   = tmr;
        r.phase = model_phase;
        r.rep   = model_valid;
        r.rdy   = model_ready;
        r.meas  = model_meas;
        r.ldo   = model_ldo_on;
        return r;
    endfunction

    function automatic string describe(input seq_result_t r);
        return $sformatf("cmd=%0d tmr=%0d phase=%0d rep=%0b rdy=%0b ldo=%0b pad=%h meas=%h",
                         r.cmd, r.tmr, r.phase, r.rep, r.rdy, r.ldo, r.pad, r.meas);
    endfunction

    // Names of the fields that differ; empty when the result matches.
    function automatic string diff_fields(input seq_result_t want, input seq_result_t got);
        string bad;
        bad = "";
        if (got.cmd   !== want.cmd)   bad = {bad, " command"};
        if (got.tmr   !== want.tmr)   bad = {bad, " timer_action"};
        if (got.phase !== want.phase) bad = {bad, " phase_now"};
        if (got.rep   !== want.rep)   bad = {bad, " report_ready"};
        if (got.rdy   !== want.rdy)   bad = {bad, " output_ready"};
        for (int m = 0; m < N_MEAS; m++)
            if (got.meas[m] !== want.meas[m]) bad = {bad, $sformatf(" meas%0d", m)};
        if (got.ldo   !== want.ldo)   bad = {bad, " ldo_is_on"};
        if (got.pad   !== want.pad)   bad = {bad, " pad"};
        return bad;
    endfunction

    function automatic seq_event_t build_event(input logic want, input logic ok,
                                               input logic [RAW_W-1:0] even_w,
                                               input logic [RAW_W-1:0] odd_w,
                                               input logic [7:0] status);
        seq_event_t e;
        e        = '0;
        e.want   = want;
        e.ok     = ok;
        e.status = status;
        for (int m = 0; m < N_MEAS; m++)
            e.meas[m] = (m % 2) ? odd_w : even_w;
        return e;
    endfunction

    // Pinned results only occur with an empty report.
    function automatic seq_result_t build_result(input logic [CMD_W-1:0] cmd,
                                                 input logic [TMR_W-1:0] tmr,
                                                 input logic [PHASE_W-1:0] phase,
                                                 input logic ldo);
        seq_result_t r;
        r       = '0;
        r.cmd   = cmd;
        r.tmr   = tmr;
        r.phase = phase;
        r.ldo   = ldo;
        return r;
    endfunction

    task automatic add_row(input logic [KIND_W-1:0] kind, input seq_event_t ev,
                           input bit typed, input seq_result_t res);
        stim_row_t row;
        row.kind  = kind;
        row.ev    = ev;
        row.typed = typed;
        row.res   = res;
        directed.push_back(row);
    endtask

    // Drives one event and returns at the edge where it is taken.
    task automatic offer(input logic [KIND_W-1:0] kind, input seq_event_t ev,
                         input bit typed, input seq_result_t res);
        pinned_t p;
        p.typed = typed;
        p.res   = res;
        pinned_rows.push_back(p);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= ev;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Burst bookkeeping: at the end of a burst, drop valid for a random gap.
    // Occasional long bursts give stretches with no source idling.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // ------------------------------------------------------------------------
    // Transfer monitor: both channels are sampled at the clock edge, before
    // any of this edge's updates, so the model sees what the DUT sees.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : transfer_monitor
        seq_result_t got;
        seq_result_t want;
        pinned_t     pin;
        bit          acted;
        string       bad;
        if (i_rst_n) begin
            // result side first: a result always belongs to an earlier event
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                results_seen++;
                if (due_results.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTED)
                        $display("[%0t] result with nothing expected: %s", $realtime,
                                 describe(got));
                end else begin
                    want = due_results.pop_front();
                    bad  = diff_fields(want, got);
                    if (bad.len() != 0) begin
                        failures++;
                        if (failures <= MAX_REPORTED) begin
                            $display("[%0t] result %0d differs in:%s", $realtime,
                                     results_seen, bad);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(got));
                        end
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                want = sequence_event(i_s_tuser, i_s_tdata, acted);
                pin  = pinned_rows.pop_front();
                if (pin.typed) want = pin.res;
                due_results.push_back(want);
                events_taken++;
                if (acted) acted_events++;
                if (want.tmr == TMR_START) readouts_armed++;
                if (want.tmr == TMR_STOP) xfer_aborts++;
                if (want.cmd == CMD_ON || want.cmd == CMD_OFF) ldo_commands++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink: alternating stall patterns, and one long hold-off on request so
    // the result register fills and the event channel backs up.
    // ------------------------------------------------------------------------
    initial begin : sink_driver
        sink_mode_t mode;
        int         span;
        int         tick;
        tick = 0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end
            mode = sink_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 64);
            repeat (span) begin
                case (mode)
                    SINK_OPEN:   i_m_tready <= 1'b1;
                    SINK_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: i_m_tready <= (tick % 4 == 0);
                    default:     i_m_tready <= ($urandom_range(0, 9) != 0);
                endcase
                tick++;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed table, random traffic, drain and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        seq_event_t        ev;
        logic [KIND_W-1:0] kind;
        int                pick;
        int                random_items;
        int                drain;

        // Directed walk; the comment gives the phase the event meets.
        // power down: stray completion is ignored, data not latched
        add_row(EV_XFER, build_event(1'b1, 1'b1, 16'h1234, 16'h5678, 8'h40), 1'b1,
                build_result(CMD_NONE, TMR_NONE, PH_DOWN, 1'b1));
        // power down: interrupt requests a readout
        add_row(EV_PIN, build_event(1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b1,
                build_result(CMD_READ, TMR_NONE, PH_READ, 1'b1));
        // readout: interrupt ignored
        add_row(EV_PIN, build_event(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0, '0);
        // readout: failed transfer drops to power down, timer stop
        add_row(EV_XFER, build_event(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b1,
                build_result(CMD_NONE, TMR_STOP, PH_DOWN, 1'b1));
        // power down: tick requests a readout
        add_row(EV_TICK, build_event(1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // readout: first report, all-ones data, LDO fix-up forced
        add_row(EV_XFER, build_event(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0, '0);
        // LDO on pending: request equal to the wanted state
        add_row(EV_LDO, build_event(1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // LDO on pending: completion, data not latched
        add_row(EV_XFER, build_event(1'b0, 1'b1, 16'h0F0F, 16'hF0F0, 8'h40), 1'b0, '0);
        // idle: periodic readout
        add_row(EV_TICK, build_event(1'b1, 1'b1, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // readout: later report, zero data, output-ready clear
        add_row(EV_XFER, build_event(1'b0, 1'b1, 16'h0000, 16'h0000, 8'hBF), 1'b0, '0);
        // idle: LDO off request
        add_row(EV_LDO, build_event(1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // LDO off pending: tick only marks a readout
        add_row(EV_TICK, build_event(1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // LDO off pending: completion, then the pending readout issues
        add_row(EV_XFER, build_event(1'b0, 1'b1, 16'h1111, 16'h2222, 8'h00), 1'b0, '0);
        // readout: LDO on request while busy
        add_row(EV_LDO, build_event(1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // readout: sign-boundary data, only the ready bit set, LDO fix-up follows
        add_row(EV_XFER, build_event(1'b0, 1'b1, 16'h8000, 16'h7FFF, 8'h40), 1'b0, '0);
        // LDO on pending: failed transfer
        add_row(EV_XFER, build_event(1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // power down: interrupt
        add_row(EV_PIN, build_event(1'b0, 1'b1, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // readout: first report again after the abort
        add_row(EV_XFER, build_event(1'b0, 1'b1, 16'hAAAA, 16'h5555, 8'h00), 1'b0, '0);
        // LDO on pending: off request while busy
        add_row(EV_LDO, build_event(1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // LDO on pending: completion, then LDO off command
        add_row(EV_XFER, build_event(1'b1, 1'b1, 16'h0000, 16'h0000, 8'hFF), 1'b0, '0);
        // LDO off pending: completion, settles idle
        add_row(EV_XFER, build_event(1'b1, 1'b1, 16'h0000, 16'h0000, 8'hFF), 1'b0, '0);
        // idle: interrupt ignored
        add_row(EV_PIN, build_event(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0, '0);
        // idle: failed completion with nothing in flight is ignored
        add_row(EV_XFER, build_event(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0, '0);
        // idle: LDO on request
        add_row(EV_LDO, build_event(1'b1, 1'b1, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);
        // LDO on pending: failed transfer
        add_row(EV_XFER, build_event(1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(1, 24);
        foreach (directed[idx]) begin
            offer(directed[idx].kind, directed[idx].ev, directed[idx].typed,
                  directed[idx].res);
            pace_sender();
        end

        // Random traffic. Completions and ticks dominate so the machine keeps
        // cycling through readouts and LDO fix-ups; failures stay rare.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = EV_XFER;
            else if (pick < 65) kind = EV_TICK;
            else if (pick < 82) kind = EV_LDO;
            else                kind = EV_PIN;
            ev        = '0;
            ev.want   = 1'($urandom_range(0, 1));
            ev.ok     = ($urandom_range(0, 9) != 0);
            ev.status = 8'($urandom_range(0, 255));
            for (int m = 0; m < N_MEAS; m++) begin
                pick = $urandom_range(0, 7);
                if (pick == 0)      ev.meas[m] = '0;
                else if (pick == 1) ev.meas[m] = '1;
                else                ev.meas[m] = RAW_W'($urandom_range(0, 65535));
            end
            if (random_items == HOLD_AT_ITEM) hold_req = 1'b1;
            offer(kind, ev, 1'b0, '0);
            random_items++;
            pace_sender();
        end
        i_s_tvalid <= 1'b0;

        drain = 0;
        while (due_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0d expected results never arrived", due_results.size());
            failures += due_results.size();
        end

        $display("Covered %0d events (%0d changed state) and checked %0d results.",
                 events_taken, acted_events, results_seen);
        $display("Timer starts %0d, aborted transfers %0d, LDO commands %0d, sink hold-offs %0d.",
                 readouts_armed, xfer_aborts, ldo_commands, holds_done);
        if (failures == 0) begin
            $display("wireless_rx_poll_sequencer: match");
        end else begin
            $display("wireless_rx_poll_sequencer: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #(WATCHDOG_CYCLES * 2 * CLK_HALF);
        $display("wireless_rx_poll_sequencer: mismatch");
        $finish;
    end

endmodule
